FILE: rtl/b32e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32e_pkg
// Shared types and constants of the base32 encoder: register indexes, the
// job record that travels from the front end to the character emitter.
// ----------------------------------------------------------------------------
package b32e_pkg;

    localparam int VAL_W      = 5;   // bits per encoded value
    localparam int GROUP_LEN  = 8;   // characters per output group
    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int JOB_DEPTH  = 2;   // job queue entries, power of two, >= 2

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD     = 3'd4;

    localparam logic [CHAR_W-1:0] PAD_RESET = 8'd61;   // '='

    // One input byte after classification: up to three values, then pads.
    typedef struct packed {
        logic             last;      // message ends with this job
        logic [2:0]       last_idx;  // index of the final character in the job
        logic [1:0]       nv;        // values to map (1..3), rest are pads
        logic [VAL_W-1:0] v2;
        logic [VAL_W-1:0] v1;
        logic [VAL_W-1:0] v0;
    } job_t;

    typedef struct packed {
        logic [2:0] leftover_count;
        logic [2:0] group_position;
    } front_stat_t;

endpackage

FILE: rtl/base32_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base32_encoder
// Base32 encoder with a programmable 32-character alphabet and pad character.
// ----------------------------------------------------------------------------
//  channel   | ports                                 | beat
//  ----------+---------------------------------------+---------------------------
//  input     | push, full, data_byte, last_byte      | push && !full
//  result    | pop, empty, out_char, last_char       | pop && !empty
//  config    | cfg_we, cfg_index, cfg_data           | cfg_we
//
// The emitter produces one character per cycle while the output is not stalled:
// a byte yields one or two characters, a final byte up to eight (flush + pads).
// Sustained input rate is set by the emitter.
// A queue of JOB_DEPTH classified bytes lets the front end run ahead.
// Reset is asynchronous, all control state clears at once; no clearing pass.
// full rises only when the job queue is full; a stalled pop holds the result.
// ----------------------------------------------------------------------------
module base32_encoder #(
    parameter int JOB_DEPTH = b32e_pkg::JOB_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        data_byte,
    input  logic                              last_byte,
    output logic                              empty,
    input  logic                              pop,
    output logic [7:0]                        out_char,
    output logic                              last_char,
    input  logic                              cfg_we,
    input  logic [b32e_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [b32e_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [63:0] alpha0_reg, alpha1_reg, alpha2_reg, alpha3_reg;
    logic [7:0]  pad_reg;

    b32e_pkg::job_t        front_job;
    b32e_pkg::job_t        head_job;
    b32e_pkg::front_stat_t front_stat;
    logic [$bits(b32e_pkg::job_t)-1:0] head_bits;
    logic        accept;
    logic        q_empty;
    logic        job_done;
    logic [2:0]  char_idx;
    logic        out_valid;

    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha0_reg <= '0;
            alpha1_reg <= '0;
            alpha2_reg <= '0;
            alpha3_reg <= '0;
            pad_reg    <= b32e_pkg::PAD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                b32e_pkg::REG_ALPHA_0: alpha0_reg <= cfg_data;
                b32e_pkg::REG_ALPHA_1: alpha1_reg <= cfg_data;
                b32e_pkg::REG_ALPHA_2: alpha2_reg <= cfg_data;
                b32e_pkg::REG_ALPHA_3: alpha3_reg <= cfg_data;
                b32e_pkg::REG_PAD:     pad_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    b32e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .job       (front_job),
        .stat      (front_stat)
    );

    b32e_fifo #(
        .WIDTH ($bits(b32e_pkg::job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_job),
        .full      (full),
        .pop       (job_done),
        .pop_data  (head_bits),
        .empty     (q_empty)
    );

    assign head_job = b32e_pkg::job_t'(head_bits);

    b32e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .alphabet  ({alpha3_reg, alpha2_reg, alpha1_reg, alpha0_reg}),
        .pad       (pad_reg),
        .job       (head_job),
        .job_valid (!q_empty),
        .job_done  (job_done),
        .char_idx  (char_idx),
        .out_char  (out_char),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_take  (pop)
    );

    assign empty = !out_valid;

    // end of message returns the regrouping state to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> (front_stat.leftover_count == 3'd0) &&
                                (front_stat.group_position == 3'd0))
        else $error("front state not cleared after final byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        front_stat.leftover_count <= 3'd4)
        else $error("leftover count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (char_idx <= head_job.last_idx))
        else $error("emitter ran past the end of its job");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> (char_idx == 3'd0))
        else $error("emitter index not parked while idle");

endmodule

FILE: rtl/b32e_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32e_fifo
// Small register queue between the front end and the character emitter.
// ----------------------------------------------------------------------------
module b32e_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW:0]      rd_ptr_reg, rd_ptr_next;
    logic             do_push, do_pop;

    assign full  = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                   (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg[AW-1:0]];

    assign wr_ptr_next = wr_ptr_reg + (AW+1)'(1);
    assign rd_ptr_next = rd_ptr_reg + (AW+1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg[AW-1:0]] <= push_data;
        end
    end

endmodule

FILE: rtl/b32e_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32e_front
// Regroups each input byte with the leftover bits into 5-bit values and
// works out the flush value and pad count at the end of a message.
// ----------------------------------------------------------------------------
module b32e_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output b32e_pkg::job_t       job,
    output b32e_pkg::front_stat_t stat
);

    logic [3:0]  leftover_bits_reg, leftover_bits_next;
    logic [2:0]  leftover_count_reg, leftover_count_next;
    logic [2:0]  group_position_reg, group_position_next;

    logic [11:0] acc;
    logic [3:0]  bits;
    logic        two;
    logic [11:0] sh0, sh1, rem_all;
    logic [3:0]  rem;
    logic [3:0]  rem_bits;
    logic [4:0]  flush_val;
    logic        has_flush;
    logic [1:0]  nv;
    logic [2:0]  gpos;
    logic [2:0]  pads;
    logic [3:0]  total;

    always_comb
    begin
        acc  = {leftover_bits_reg, data_byte};
        bits = {1'b0, leftover_count_reg} + 4'd8;
        two  = (bits >= 4'd10);
        sh0  = acc >> (bits - 4'd5);
        sh1  = acc >> (bits - 4'd10);
        rem  = two ? (bits - 4'd10) : (bits - 4'd5);
        rem_all  = acc & ((12'd1 << rem) - 12'd1);
        rem_bits = rem_all[3:0];
        // zero-fill the tail up to a full value
        flush_val = {1'b0, rem_bits} << (4'd5 - rem);
        has_flush = last_byte && (rem != 4'd0);
        nv   = (two ? 2'd2 : 2'd1) + {1'b0, has_flush};
        gpos = group_position_reg + {1'b0, nv};
        pads = last_byte ? (3'd0 - gpos) : 3'd0;
        total = {2'b00, nv} + {1'b0, pads};
        if (total > 4'd8)
        begin
            total = 4'd8;
        end

        job.last     = last_byte;
        job.last_idx = 3'(total - 4'd1);
        job.nv       = nv;
        job.v0       = sh0[4:0];
        job.v1       = two ? sh1[4:0] : flush_val;
        job.v2       = flush_val;

        if (last_byte)
        begin
            leftover_bits_next  = '0;
            leftover_count_next = '0;
            group_position_next = '0;
        end
        else
        begin
            leftover_bits_next  = rem_bits;
            leftover_count_next = rem[2:0];
            group_position_next = gpos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leftover_bits_reg  <= '0;
            leftover_count_reg <= '0;
            group_position_reg <= '0;
        end
        else if (accept)
        begin
            leftover_bits_reg  <= leftover_bits_next;
            leftover_count_reg <= leftover_count_next;
            group_position_reg <= group_position_next;
        end
    end

    assign stat.leftover_count = leftover_count_reg;
    assign stat.group_position = group_position_reg;

endmodule

FILE: rtl/b32e_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b32e_back
// Steps through the head job one character per cycle while not stalled, mapping
// values through the alphabet and appending pads, into the output register.
// ----------------------------------------------------------------------------
module b32e_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [255:0]   alphabet,
    input  logic [7:0]     pad,
    input  b32e_pkg::job_t job,
    input  logic           job_valid,
    output logic           job_done,
    output logic [2:0]     char_idx,
    output logic [7:0]     out_char,
    output logic           last_char,
    output logic           out_valid,
    input  logic           out_take
);

    logic [2:0] idx_reg;
    logic [7:0] char_reg, char_next;
    logic       last_reg;
    logic       valid_reg;
    logic       advance;
    logic [4:0] val;
    logic       is_val;
    logic       at_end;

    assign advance  = job_valid && (!valid_reg || out_take);
    assign at_end   = (idx_reg == job.last_idx);
    assign job_done = advance && at_end;

    always_comb
    begin
        is_val = ({1'b0, idx_reg} < {2'b00, job.nv});
        case (idx_reg[1:0])
            2'd0:    val = job.v0;
            2'd1:    val = job.v1;
            default: val = job.v2;
        endcase
        char_next = is_val ? alphabet[{val, 3'b000} +: 8] : pad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= at_end ? 3'd0 : idx_reg + 3'd1;
        end
        else if (out_take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            char_reg <= char_next;
            last_reg <= job.last && at_end;
        end
    end

    assign char_idx  = idx_reg;
    assign out_char  = char_reg;
    assign last_char = last_reg;
    assign out_valid = valid_reg;

endmodule
